// ===== hdl/sv39ptw_pkg.sv =====
package sv39ptw_pkg;

	localparam int TABLE_PAGES       = 64;
	localparam int ENTRIES_PER_TABLE = 512;
	localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
	localparam int PAGE_W            = $clog2(TABLE_PAGES);
	localparam int ADDR_W            = PAGE_W + IDX_W;
	localparam int NFP_W             = $clog2(TABLE_PAGES + 1);
	localparam int STORE_DEPTH       = TABLE_PAGES * ENTRIES_PER_TABLE;

	localparam int PTE_W  = 64;
	localparam int PPN_W  = 44;
	localparam int FLAG_W = 10;
	localparam int VA_W   = 39;
	localparam int PA_W   = 56;

	localparam logic [FLAG_W-1:0] PTE_V = 10'h001;

	localparam logic [1:0] FN_TRANSLATE = 2'd0;
	localparam logic [1:0] FN_MAP       = 2'd1;
	localparam logic [1:0] FN_UNMAP     = 2'd2;
	localparam logic [1:0] FN_NOP       = 2'd3;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_VA_LARGE   = 3'd1;
	localparam logic [2:0] ST_NOT_MAPPED = 3'd2;
	localparam logic [2:0] ST_NOT_USER   = 3'd3;
	localparam logic [2:0] ST_REMAP      = 3'd4;
	localparam logic [2:0] ST_NO_PAGE    = 3'd5;
	localparam logic [2:0] ST_NOT_LEAF   = 3'd6;
	localparam logic [2:0] ST_BAD_PTR    = 3'd7;

	typedef struct packed {
		logic [1:0]      func;
		logic [VA_W-1:0] virt_addr;
		logic [PA_W-1:0] phys_addr;
		logic [4:0]      perm;
		logic            free_page;
	} ptw_req_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [PA_W-1:0] result_addr;
		logic            free_request;
	} ptw_rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_L2,
		S_L1,
		S_L0,
		S_RESP
	} walk_state_t;

endpackage

// ===== hdl/sv39ptw_ram.sv =====
module sv39ptw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/sv39_page_table_walker_top.sv =====
// A full walk goes through S_L2, S_L1 and S_L0 and registers its result in
// out_data_q; a bad address or no-op is answered from S_IDLE, an early walk
// fault from S_L2 or S_L1. A stalled result waits in pend_q in S_RESP.
// One item at a time, with three dependent reads of the table store plus the
// leaf update per full walk. Reset: asynchronous; the block then zeroes all
// STORE_DEPTH (32768) entries, one entry a cycle, before it takes an input beat.
module sv39_page_table_walker_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sv39ptw_pkg::PPN_W-1:0]  cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  sv39ptw_pkg::ptw_req_t          in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output sv39ptw_pkg::ptw_rsp_t          out_data
);

	import sv39ptw_pkg::*;

	walk_state_t       state_q, state_d;
	ptw_req_t          req_q;
	logic [ADDR_W-1:0] slot_q;
	logic [ADDR_W-1:0] clr_q;
	logic [NFP_W-1:0]  nfp_q;
	logic [PPN_W-1:0]  base_q;
	ptw_rsp_t          pend_q;
	ptw_rsp_t          out_data_q;
	logic              out_valid_q;

	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [PTE_W-1:0]  rd_data;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [PTE_W-1:0]  wr_data;

	logic              done;
	logic              alloc;
	ptw_rsp_t          res_d;
	logic              out_free;
	logic              load_out;
	logic [PPN_W-1:0]  rel;
	logic              in_pool;
	logic [IDX_W-1:0]  cur_vpn;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = out_free && (done || state_q == S_RESP);

	// Pointer check: entry page number relative to the pool must name an allocated page
	assign rel     = rd_data[FLAG_W +: PPN_W] - base_q;
	assign in_pool = (rel[PPN_W-1:PAGE_W] == '0) &&
	                 (NFP_W'(rel[PAGE_W-1:0]) < nfp_q);
	assign cur_vpn = (state_q == S_L2) ? req_q.virt_addr[29:21] : req_q.virt_addr[20:12];

	sv39ptw_ram #(
		.WIDTH(PTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = slot_q;
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = '0;
		done    = 1'b0;
		alloc   = 1'b0;
		res_d   = '0;
		res_d.status = ST_OK;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: begin
				if (in_valid) begin
					if (in_data.func == FN_NOP) begin
						done = 1'b1;
					end else if (in_data.virt_addr[VA_W-1]) begin
						done         = 1'b1;
						res_d.status = ST_VA_LARGE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = {PAGE_W'(0), in_data.virt_addr[38:30]};
					end
				end
			end
			S_L2, S_L1: begin
				if (rd_data[0]) begin
					if (in_pool) begin
						rd_en   = 1'b1;
						rd_addr = {rel[PAGE_W-1:0], cur_vpn};
					end else begin
						done         = 1'b1;
						res_d.status = ST_BAD_PTR;
					end
				end else if (req_q.func != FN_MAP) begin
					done         = 1'b1;
					res_d.status = ST_NOT_MAPPED;
				end else if (nfp_q >= NFP_W'(TABLE_PAGES)) begin
					done         = 1'b1;
					res_d.status = ST_NO_PAGE;
				end else begin
					// Hook a fresh page into this slot and walk into it
					alloc   = 1'b1;
					wr_en   = 1'b1;
					wr_data = {10'b0, base_q + PPN_W'(nfp_q), PTE_V};
					rd_en   = 1'b1;
					rd_addr = {nfp_q[PAGE_W-1:0], cur_vpn};
				end
			end
			S_L0: begin
				done = 1'b1;
				case (req_q.func)
					FN_MAP: begin
						if (rd_data[0]) begin
							res_d.status = ST_REMAP;
						end else begin
							wr_en   = 1'b1;
							wr_data = {10'b0, req_q.phys_addr[PA_W-1:12], 5'b0,
							           req_q.perm[4:1], 1'b1};
						end
					end
					FN_UNMAP: begin
						if (!rd_data[0]) begin
							res_d.status = ST_NOT_MAPPED;
						end else if (rd_data[FLAG_W-1:0] == PTE_V) begin
							res_d.status = ST_NOT_LEAF;
						end else begin
							res_d.result_addr  = {rd_data[FLAG_W +: PPN_W], 12'b0};
							res_d.free_request = req_q.free_page;
							wr_en              = 1'b1;
						end
					end
					default: begin
						if (!rd_data[0]) begin
							res_d.status = ST_NOT_MAPPED;
						end else if (!rd_data[4]) begin
							res_d.status = ST_NOT_USER;
						end else begin
							res_d.result_addr = {rd_data[FLAG_W +: PPN_W], 12'b0};
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == ADDR_W'(STORE_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (!done) begin
						state_d = S_L2;
					end else if (!out_free) begin
						state_d = S_RESP;
					end
				end
			end
			S_L2: begin
				if (!done) begin
					state_d = S_L1;
				end else begin
					state_d = out_free ? S_IDLE : S_RESP;
				end
			end
			S_L1: begin
				if (!done) begin
					state_d = S_L0;
				end else begin
					state_d = out_free ? S_IDLE : S_RESP;
				end
			end
			S_L0: begin
				state_d = out_free ? S_IDLE : S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			nfp_q       <= NFP_W'(1);
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (alloc) begin
				nfp_q <= nfp_q + NFP_W'(1);
			end
			if (cfg_wr_en) begin
				base_q <= cfg_wr_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_q <= in_data;
		end
		if (rd_en) begin
			slot_q <= rd_addr;
		end
		// Park the result while the output beat is still stalled
		if (done && !out_free) begin
			pend_q <= res_d;
		end
		if (load_out) begin
			out_data_q <= done ? res_d : pend_q;
		end
	end

endmodule

// ===== hdl/sv39ptw_checker.sv =====
module sv39ptw_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic                  out_valid,
	input logic                  out_stall,
	input sv39ptw_pkg::ptw_rsp_t out_data
);

	import sv39ptw_pkg::*;

	// Result addresses are page bases: the offset bits stay clear
	a_page_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.result_addr[11:0] == '0)
		else $error("result address not page aligned");

	a_free_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.free_request |-> out_data.status == ST_OK)
		else $error("free request on a failed operation");

	a_fault_zero_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |-> out_data.result_addr == '0)
		else $error("nonzero address on a fault");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output beat changed");

endmodule

bind sv39_page_table_walker_top sv39ptw_checker u_chk (.*);
